@@ hdl/swm_pkg.sv @@
// Shared types and constants for the sliding window median filter.
// No dependencies; used by swm_cell, sliding_window_median and tb_top.
package swm_pkg;

  localparam int WINDOW_MAX_DEF = 64;        // default deepest window
  localparam int DATA_W         = 32;        // sample width
  localparam int CFG_W          = 7;         // window_size register width
  localparam int WIN_RST        = 3;         // window_size after reset

  // Flipping the sign bit maps signed order onto unsigned order.
  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } st_e;

  // Broadcast to every cell of the sorted row.
  typedef struct packed {
    logic              upd;      // load new contents this cycle
    logic              rm;       // drop one copy of rm_key first
    logic [DATA_W-1:0] rm_key;   // oldest sample, offset binary
    logic [DATA_W-1:0] ins_key;  // new sample, offset binary
  } cell_ctl_t;

endpackage

@@ hdl/sliding_window_median.sv @@
// Sliding window median filter: top level with handshakes, control and cell row.
// Depends on swm_pkg, swm_cell and swm_ram.
//
// Takes signed 32-bit samples and, once window_size samples have arrived,
// returns for that sample and each further one the lower median (sorted position
// (window_size-1)/2) of the last window_size samples. The window is kept
// sorted in a row of WINDOW_MAX cells; each cell compares against its two
// neighbors so one sample removes the oldest key and inserts the new one in
// the same update. Arrival order lives in a RAM ring that supplies the
// key to drop. Each sample goes through accept (ring read issued), cell row
// update (ring read data arrives) and median selection into the output register.
// The output register holds a result while the next sample is accepted; a
// stalled output only holds the block in the selection cycle. window_size 0
// acts as 1 and values above WINDOW_MAX saturate. Writing window_size, or a
// sample with restart (tuser) set, empties the window first. No clearing pass
// after reset: the row and ring are only read where written.
module sliding_window_median #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write: window_size
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_data_i,   // [6:0] window_size
  // sample stream
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [swm_pkg::DATA_W-1:0]    s_tdata_i,    // [31:0] sample
  input  logic [0:0]                    s_tuser_i,    // [0] restart
  // median stream
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [swm_pkg::DATA_W-1:0]    m_tdata_o     // [31:0] median
);

  localparam int DW    = swm_pkg::DATA_W;
  localparam int FW    = $clog2(WINDOW_MAX + 1);              // fill count / size
  localparam int IW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;  // cell index
  localparam int SW    = (FW > swm_pkg::CFG_W) ? FW : swm_pkg::CFG_W;
  localparam int K_RST = (swm_pkg::WIN_RST > WINDOW_MAX) ? WINDOW_MAX : swm_pkg::WIN_RST;

  // ---------------------------------------------------------------------------
  // Window size register: saturated size and median position
  // ---------------------------------------------------------------------------
  logic [FW-1:0] k_q, k_d;
  logic [IW-1:0] med_q, med_d;
  logic [SW-1:0] cfg_ext;
  logic          cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign cfg_ext     = SW'(cfg_data_i);

  always_comb begin
    if (cfg_ext == '0) begin
      k_d = FW'(1);
    end else if (cfg_ext > SW'(WINDOW_MAX)) begin
      k_d = FW'(WINDOW_MAX);
    end else begin
      k_d = cfg_ext[FW-1:0];
    end
    med_d = IW'((k_d - FW'(1)) >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= FW'(K_RST);
      med_q <= IW'((K_RST - 1) / 2);
    end else if (cfg_xfer) begin
      k_q   <= k_d;
      med_q <= med_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state machine
  // ---------------------------------------------------------------------------
  swm_pkg::st_e state_q, state_d;

  logic          s_xfer, m_xfer;
  logic          result;       // window full after update
  logic          load_en;      // median goes to the output register
  logic          upd;
  logic          ram_re;

  assign s_xfer = s_tvalid_i && s_tready_o;
  assign m_xfer = m_tvalid_o && m_tready_i;

  logic [FW-1:0] fill_q, fill_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic          out_valid_q;

  assign result = (fill_q == k_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        if (s_xfer) begin
          state_d = swm_pkg::ST_UPDATE;
        end
      end
      swm_pkg::ST_UPDATE: begin
        state_d = swm_pkg::ST_EMIT;
      end
      swm_pkg::ST_EMIT: begin
        if (!result || !out_valid_q || m_tready_i) begin
          state_d = swm_pkg::ST_IDLE;
        end
      end
      default: state_d = swm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    ram_re     = 1'b0;
    upd        = 1'b0;
    load_en    = 1'b0;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        ram_re     = s_tvalid_i;
      end
      swm_pkg::ST_UPDATE: begin
        upd = 1'b1;
      end
      swm_pkg::ST_EMIT: begin
        load_en = result && (!out_valid_q || m_tready_i);
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Accepted sample
  // ---------------------------------------------------------------------------
  logic [DW-1:0] key_q;
  logic          restart_q;

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      key_q <= s_tdata_i ^ swm_pkg::SIGN_FLIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= 1'b0;
    end else if (s_xfer) begin
      restart_q <= s_tuser_i[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Fill count and oldest pointer
  // ---------------------------------------------------------------------------
  logic [FW-1:0] fill_eff;     // fill after a possible restart
  logic          rm;           // window full: oldest sample leaves
  logic [FW-1:0] ptr_inc;
  logic [IW-1:0] ring_waddr;

  assign fill_eff = restart_q ? '0 : fill_q;
  assign rm       = !restart_q && (fill_q == k_q);
  assign ptr_inc  = FW'(ptr_q) + FW'(1);

  always_comb begin
    fill_d     = fill_q;
    ptr_d      = ptr_q;
    ring_waddr = fill_eff[IW-1:0];
    if (cfg_xfer) begin
      fill_d = '0;
      ptr_d  = '0;
    end else if (upd) begin
      if (rm) begin
        ring_waddr = ptr_q;
        ptr_d      = (ptr_inc == k_q) ? '0 : ptr_inc[IW-1:0];
      end else begin
        fill_d = fill_eff + FW'(1);
        ptr_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ptr_q  <= '0;
    end else begin
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Arrival ring: read oldest at accept, write new key in the update cycle
  // ---------------------------------------------------------------------------
  logic [DW-1:0] oldest_key;

  swm_ram #(
    .WIDTH (DW),
    .DEPTH (WINDOW_MAX),
    .AW    (IW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (upd),
    .waddr_i (ring_waddr),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (oldest_key)
  );

  // ---------------------------------------------------------------------------
  // Sorted cell row
  // ---------------------------------------------------------------------------
  swm_pkg::cell_ctl_t cell_ctl;

  assign cell_ctl.upd     = upd;
  assign cell_ctl.rm      = rm;
  assign cell_ctl.rm_key  = oldest_key;
  assign cell_ctl.ins_key = key_q;

  logic [DW-1:0] cell_val [WINDOW_MAX];
  logic [DW-1:0] cell_rem [WINDOW_MAX];
  logic          cell_rem_occ [WINDOW_MAX];
  logic          occ [WINDOW_MAX];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic          nxt_occ;
    logic [DW-1:0] nxt_val;
    logic          prv_occ;
    logic [DW-1:0] prv_rem;

    assign occ[i] = (fill_eff > FW'(i));

    if (i < WINDOW_MAX - 1) begin : g_up
      assign nxt_occ = occ[i+1];
      assign nxt_val = cell_val[i+1];
    end else begin : g_top
      assign nxt_occ = 1'b0;
      assign nxt_val = '0;
    end

    if (i > 0) begin : g_dn
      assign prv_occ = cell_rem_occ[i-1];
      assign prv_rem = cell_rem[i-1];
    end else begin : g_bot
      assign prv_occ = 1'b0;
      assign prv_rem = '0;
    end

    swm_cell u_cell (
      .clk_i          (clk_i),
      .ctl_i          (cell_ctl),
      .occ_i          (occ[i]),
      .next_occ_i     (nxt_occ),
      .next_val_i     (nxt_val),
      .prev_rem_occ_i (prv_occ),
      .prev_rem_i     (prv_rem),
      .val_o          (cell_val[i]),
      .rem_occ_o      (cell_rem_occ[i]),
      .rem_o          (cell_rem[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [DW-1:0] median_q;

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      median_q <= cell_val[med_q] ^ swm_pkg::SIGN_FLIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_en) begin
      out_valid_q <= 1'b1;
    end else if (m_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = median_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic [WINDOW_MAX-1:0] order_ok;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_chk
    if (i > 0) begin : g_pair
      assign order_ok[i] = (fill_q <= FW'(i)) || (cell_val[i-1] <= cell_val[i]);
    end else begin : g_first
      assign order_ok[i] = 1'b1;
    end
  end

  a_fill_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_q)
    else $error("fill count above window size");

  a_ptr_lt_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(ptr_q) < k_q)
    else $error("oldest pointer outside window");

  a_row_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swm_pkg::ST_IDLE) |-> (&order_ok))
    else $error("cell row out of order");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_tready_i) |=> !$past(load_en))
    else $error("waiting result overwritten");

endmodule

@@ hdl/swm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/swm_cell.sv @@
// One position of the sorted row: holds one key, removes and inserts locally.
// Depends on swm_pkg.
module swm_cell (
  input  logic                     clk_i,
  input  swm_pkg::cell_ctl_t       ctl_i,
  input  logic                     occ_i,          // this position holds a sample
  input  logic                     next_occ_i,     // upper neighbor holds a sample
  input  logic [swm_pkg::DATA_W-1:0] next_val_i,   // upper neighbor key
  input  logic                     prev_rem_occ_i, // lower neighbor occupied after removal
  input  logic [swm_pkg::DATA_W-1:0] prev_rem_i,   // lower neighbor key after removal
  output logic [swm_pkg::DATA_W-1:0] val_o,
  output logic                     rem_occ_o,
  output logic [swm_pkg::DATA_W-1:0] rem_o
);

  logic [swm_pkg::DATA_W-1:0] val_q, val_d;

  // Removal: shift down when the upper neighbor is above the removed key.
  // Of a run of equal keys this drops the last copy.
  always_comb begin
    rem_occ_o = ctl_i.rm ? next_occ_i : occ_i;
    rem_o     = val_q;
    if (ctl_i.rm && next_occ_i && (next_val_i > ctl_i.rm_key)) begin
      rem_o = next_val_i;
    end
  end

  // Insertion: keep if at or below the new key, else shift up or take it.
  always_comb begin
    if (rem_occ_o && (rem_o <= ctl_i.ins_key)) begin
      val_d = rem_o;
    end else if (prev_rem_occ_i && (prev_rem_i > ctl_i.ins_key)) begin
      val_d = prev_rem_i;
    end else begin
      val_d = ctl_i.ins_key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

@@ dv/tb_top.sv @@
// Testbench for the sliding window median filter: directed table, then random phases.
// Depends on swm_pkg and sliding_window_median; predicts every median and checks
// each median transfer in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int WMAX    = WINDOW_MAX_DEF;
  localparam int RAND_N  = 650;   // random samples in total
  localparam int GAP_MAX = 18;    // longest per-transfer idle on either side
  localparam int HOLD_N  = 300;   // long sink hold-off, forces input backpressure
  localparam int SETTLE  = 8;     // quiet cycles once results are in (3-stage pipe)

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i;    // [6:0] window_size
  logic              s_tvalid_i;
  logic              s_tready_o;
  logic [DATA_W-1:0] s_tdata_i;     // [31:0] sample
  logic [0:0]        s_tuser_i;     // [0] restart
  logic              m_tvalid_o;
  logic              m_tready_i;
  logic [DATA_W-1:0] m_tdata_o;     // [31:0] median

  sliding_window_median uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: window contents kept in offset binary (sign bit flipped)
  // so plain unsigned compares give the signed order.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] arrival   [WMAX];   // arrival-order ring
  logic [DATA_W-1:0] sorted_w  [WMAX];   // ascending window contents
  int unsigned       fill_cnt;
  int unsigned       oldest_pos;
  logic [CFG_W-1:0]  win_reg;

  logic [DATA_W-1:0] pending_medians [$];  // medians still owed by the DUT
  int unsigned       mismatch_cnt;
  bit                tx_burst;             // sender runs back to back
  bit                rx_burst;             // sink always ready
  bit                hold_req;             // asks the sink for one long hold-off

  // queue one owed median at the tail
  function automatic void owe_median(input logic [DATA_W-1:0] m);
    pending_medians = {pending_medians, m};
  endfunction

  // 0 acts as 1, anything past WMAX saturates
  function automatic int unsigned win_eff();
    int unsigned k;
    k = win_reg;
    if (k == 0) k = 1;
    if (k > WMAX) k = WMAX;
    return k;
  endfunction

  // Advance the window by one sample; returns 1 when a median is due.
  function automatic bit median_predict(input logic [DATA_W-1:0] smp, input logic restart_f,
                                        output logic [DATA_W-1:0] med);
    int unsigned k;
    int unsigned p;
    int unsigned j;
    logic [DATA_W-1:0] key;
    bit gone;
    k   = win_eff();
    key = smp ^ SIGN_FLIP;
    med = '0;
    if (restart_f) begin
      fill_cnt   = 0;
      oldest_pos = 0;
    end
    if (fill_cnt < k) begin
      // still filling: ring is written in order from slot 0
      arrival[fill_cnt] = key;
    end else begin
      p = oldest_pos % k;
      // drop exactly one copy of the oldest value
      gone = 1'b0;
      for (int i = 0; i < fill_cnt && !gone; i++) begin
        if (sorted_w[i] == arrival[p]) begin
          for (int m = i; m + 1 < fill_cnt; m++) sorted_w[m] = sorted_w[m+1];
          fill_cnt--;
          gone = 1'b1;
        end
      end
      arrival[p] = key;
      oldest_pos = (p + 1) % k;
    end
    // insertion into the sorted row
    j = fill_cnt;
    while (j > 0 && sorted_w[j-1] > key) begin
      sorted_w[j] = sorted_w[j-1];
      j--;
    end
    sorted_w[j] = key;
    fill_cnt++;
    if (fill_cnt < k) return 1'b0;
    med = sorted_w[(k - 1) / 2] ^ SIGN_FLIP;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Medians are typed in where they are obvious; other rows
  // fall back on the predictor.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [DATA_W-1:0] value;      // sample, or window_size in the low bits
    logic              restart;
    logic              typed;      // typed_med is the expected median
    logic [DATA_W-1:0] typed_med;
  } dir_row_t;

  localparam int DIR_N = 19;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    // window 3 out of reset
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},  // most negative
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},  // most positive
    '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},  // first full window
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000},  // min leaves
    '{ROW_SAMPLE, 32'd100,       1'b1, 1'b0, 32'h0000_0000},  // restart mid-stream
    '{ROW_SAMPLE, 32'd100,       1'b0, 1'b0, 32'h0000_0000},
    '{ROW_SAMPLE, 32'd100,       1'b0, 1'b1, 32'd100},
    '{ROW_SAMPLE, 32'hFFFF_FFFB, 1'b0, 1'b1, 32'd100},        // one duplicate leaves
    '{ROW_SAMPLE, 32'hFFFF_FFFB, 1'b0, 1'b1, 32'hFFFF_FFFB},
    // window 0 behaves as 1
    '{ROW_CFG,    32'd0,         1'b0, 1'b0, 32'h0000_0000},
    '{ROW_SAMPLE, 32'd42,        1'b0, 1'b1, 32'd42},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},  // restart, window of one
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
    // window 2: lower median is the smaller one
    '{ROW_CFG,    32'd2,         1'b0, 1'b0, 32'h0000_0000},
    '{ROW_SAMPLE, 32'd9,         1'b0, 1'b0, 32'h0000_0000},
    '{ROW_SAMPLE, 32'd3,         1'b0, 1'b1, 32'd3},
    '{ROW_SAMPLE, 32'd10,        1'b0, 1'b1, 32'd3},
    // all-ones register saturates to the deepest window
    '{ROW_CFG,    32'd127,       1'b0, 1'b0, 32'h0000_0000},
    '{ROW_SAMPLE, 32'd1,         1'b0, 1'b0, 32'h0000_0000}
  };

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Worst case is far below this: ~700 samples with their gaps, plus phase drains.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sample source
  // ---------------------------------------------------------------------------
  // One sample transfer. Valid stays high straight into the next sample when
  // no gap is drawn, so valid is never dropped and raised in one step.
  task automatic push_sample(input logic [DATA_W-1:0] smp, input logic restart_f,
                             input logic typed, input logic [DATA_W-1:0] typed_med);
    int unsigned gap;
    logic [DATA_W-1:0] med;
    bit due;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= smp;
    s_tuser_i  <= restart_f;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    due = median_predict(smp, restart_f, med);
    if (typed) owe_median(typed_med);
    else if (due) owe_median(med);
  endtask

  // Window size only changes with the pipe empty: wait out every owed median,
  // then the SETTLE wait for a sample that produced none.
  task automatic write_window(input logic [CFG_W-1:0] size);
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    win_reg    = size;
    fill_cnt   = 0;
    oldest_pos = 0;
  endtask

  // Mix of full-range values, a narrow band (lots of duplicates) and extremes.
  function automatic logic [DATA_W-1:0] draw_sample();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3, 4: begin
        v = $urandom_range(0, 8);
        v = v - 32'd4;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin : sample_source
    logic [CFG_W-1:0] size;
    int unsigned sent;
    int unsigned phase;
    int unsigned n;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = '0;
    m_tready_i  = 1'b0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    hold_req    = 1'b0;
    mismatch_cnt = 0;
    win_reg     = CFG_W'(WIN_RST);
    fill_cnt    = 0;
    oldest_pos  = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, first rows run on the reset window size
    for (int r = 0; r < DIR_N; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) write_window(DIRECTED[r].value[CFG_W-1:0]);
      else push_sample(DIRECTED[r].value, DIRECTED[r].restart,
                       DIRECTED[r].typed, DIRECTED[r].typed_med);
    end

    // random phases: new window size, then a burst of samples long enough to
    // fill the window and slide it well past full
    sent  = 0;
    phase = 0;
    while (sent < RAND_N) begin
      if (phase == 0) size = CFG_W'(WMAX);
      else begin
        case ($urandom_range(0, 11))
          0:       size = '0;
          1:       size = CFG_W'(WMAX);
          2:       size = CFG_W'($urandom_range(WMAX + 1, 127));
          3:       size = CFG_W'($urandom_range(10, 20));
          default: size = CFG_W'($urandom_range(1, 9));
        endcase
      end
      write_window(size);
      n = win_eff() + $urandom_range(15, 45);
      // last phase stops at the sample budget
      if (n > RAND_N - sent) n = RAND_N - sent;
      tx_burst = ($urandom_range(0, 3) == 0);
      // one long sink stall while the source keeps offering
      if (phase == 1) hold_req = 1'b1;
      for (int i = 0; i < n; i++) begin
        push_sample(draw_sample(), $urandom_range(0, 24) == 0, 1'b0, '0);
        sent++;
      end
      phase++;
    end
    s_tvalid_i <= 1'b0;

    // drain, then the SETTLE wait for anything stray
    @(posedge clk_i);
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Median sink: random ready gaps per transfer, burst stretches, one long hold
  // ---------------------------------------------------------------------------
  initial begin : median_sink
    int unsigned wait_cyc;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      wait_cyc = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (hold_req) begin
        wait_cyc = HOLD_N;
        hold_req = 1'b0;
      end
      if (wait_cyc != 0) begin
        m_tready_i <= 1'b0;
        repeat (wait_cyc) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid_o) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every median transfer against the oldest owed median
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : median_check
    logic [DATA_W-1:0] want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_medians.size() == 0) begin
        $error("median: none expected, actual %0d", $signed(m_tdata_o));
        mismatch_cnt++;
      end else begin
        want = pending_medians.pop_front();
        if (m_tdata_o !== want) begin
          $error("median: expected %0d, actual %0d", $signed(want), $signed(m_tdata_o));
          mismatch_cnt++;
        end
      end
    end
  end

endmodule

@@ sim.f @@
hdl/swm_pkg.sv
hdl/swm_ram.sv
hdl/swm_cell.sv
hdl/sliding_window_median.sv
dv/tb_top.sv
